// ===== rtl/lfrs_pkg.sv =====
// shared constants and types for the lowest free room scheduler
`default_nettype none

package lfrs_pkg;

	localparam int DEF_MAX_ROOMS = 16;
	localparam int DEF_TIME_BITS = 48;

	localparam int CFG_W       = 5;
	localparam int REQ_TIME_W  = 32;
	localparam int COUNT_W     = 32;
	localparam int ROOM_OUT_W  = 4;
	localparam int OUT_TIME_W  = 48;

	localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

	// slave beat: start_time, end_time
	localparam int S_TDATA_W = 2 * REQ_TIME_W;
	// master beat: room, actual_begin, actual_finish, was_delayed, busiest_room, busiest_count
	localparam int M_FIELDS_W = 2 * ROOM_OUT_W + 2 * OUT_TIME_W + 1 + COUNT_W;
	localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
	localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PICK,
		ST_UPD
	} lfrs_state_t;

endpackage

`default_nettype wire

// ===== rtl/lfrs_ram.sv =====
// generic single write port, single read port ram with registered read
`default_nettype none

module lfrs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/lowest_free_room_scheduler.sv =====
// top level of the lowest free room scheduler
`default_nettype none

// Booking scheduler: each slave beat is one booking (start_time, end_time), and bookings
// must arrive in nondecreasing start order. The block gives the lowest active room whose
// busy-until time is at or before the start; if none is free it gives the room that frees
// earliest (lower index on ties) and shifts the booking to that time with the same
// duration, the finish saturating at the top of the time range. Every result beat also
// carries the running most-booked room (lowest index on ties) and its saturating count.
// Room busy times and booking counts live in two rams with a registered read; a valid
// bit per room makes a never-written room read as zero, so there is no clearing pass
// after reset. A booking is accepted in ST_IDLE, then ST_SCAN streams the busy times of
// the n active rooms (n being rooms_in_use clamped to 1..MAX_ROOMS) out of the ram
// through the compare, ST_PICK forms the times and reads the count, and ST_UPD writes
// back both rams and loads the result register. The result register lets the last
// result wait on m_tready while the next booking is scanned; the write-back cycle stalls
// only if that result is still not taken. rooms_in_use is written through cfg_wr_en /
// cfg_wr_data and must only change while the block is idle.
module lowest_free_room_scheduler #(
	parameter int MAX_ROOMS = lfrs_pkg::DEF_MAX_ROOMS,
	parameter int TIME_BITS = lfrs_pkg::DEF_TIME_BITS
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// configuration: rooms_in_use
	input  wire logic                             cfg_wr_en,
	input  wire logic [lfrs_pkg::CFG_W-1:0]       cfg_wr_data,
	// booking beats
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// start_time, end_time
	input  wire logic [lfrs_pkg::S_TDATA_W-1:0]   s_tdata,
	// result beats
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// room, actual_begin, actual_finish, was_delayed, busiest_room, busiest_count, zero pad
	output logic      [lfrs_pkg::M_TDATA_W-1:0]   m_tdata
);

	localparam int RIDX_W = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
	localparam int CNT_W  = $clog2(MAX_ROOMS + 1);
	localparam int RW     = lfrs_pkg::REQ_TIME_W;
	localparam int CW     = lfrs_pkg::COUNT_W;

	// control state
	lfrs_pkg::lfrs_state_t state_q, state_d;
	logic [lfrs_pkg::CFG_W-1:0] cfg_q;
	logic [MAX_ROOMS-1:0]       valid_q;
	logic                       rv_s1;
	logic                       m_tvalid_q;
	logic [RIDX_W-1:0]          best_room_q;
	logic [CW-1:0]              best_count_q;

	// per-booking payload
	logic [RW-1:0]        start_q, end_q, dur_q;
	logic [CNT_W-1:0]     ra_q;
	logic [RIDX_W-1:0]    ri_s1;
	logic                 found_q;
	logic [RIDX_W-1:0]    pick_q, min_idx_q;
	logic [TIME_BITS-1:0] min_q, begin_q, finish_q;
	logic [lfrs_pkg::M_TDATA_W-1:0] m_tdata_q;

	// handshake and strobes from the sequencer
	logic accept, fa_rd_en, bk_rd_en, can_load, wb_en;

	// ram ports
	logic [TIME_BITS-1:0] fa_rdata;
	logic [CW-1:0]        bk_rdata;
	logic [RIDX_W-1:0]    bk_rd_addr;

	// active room count, rooms_in_use clamped to 1..MAX_ROOMS
	logic [CNT_W-1:0] n_rooms;
	always_comb begin
		if (cfg_q == '0) begin
			n_rooms = CNT_W'(1);
		end else if (32'(cfg_q) > 32'(MAX_ROOMS)) begin
			n_rooms = CNT_W'(MAX_ROOMS);
		end else begin
			n_rooms = CNT_W'(cfg_q);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lfrs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		fa_rd_en = 1'b0;
		bk_rd_en = 1'b0;
		wb_en    = 1'b0;
		can_load = !m_tvalid_q || m_tready;
		case (state_q)
			lfrs_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = lfrs_pkg::ST_SCAN;
				end
			end
			lfrs_pkg::ST_SCAN: begin
				fa_rd_en = (ra_q < n_rooms);
				// the last busy time is compared in the same cycle
				if (ra_q == n_rooms && rv_s1) begin
					state_d = lfrs_pkg::ST_PICK;
				end
			end
			lfrs_pkg::ST_PICK: begin
				bk_rd_en = 1'b1;
				state_d  = lfrs_pkg::ST_UPD;
			end
			lfrs_pkg::ST_UPD: begin
				if (can_load) begin
					wb_en   = 1'b1;
					state_d = lfrs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lfrs_pkg::ST_IDLE;
			end
		endcase
	end

	assign accept = s_tvalid && s_tready;

	// busy time of the room whose read just came back, zero if never written
	logic [TIME_BITS-1:0] fa_cur;
	assign fa_cur = valid_q[ri_s1] ? fa_rdata : '0;

	// delayed finish, saturating
	logic [TIME_BITS:0] sum;
	assign sum = {1'b0, min_q} + (TIME_BITS + 1)'(dur_q);

	// count update and running busiest room
	logic [CW-1:0]     c_cur, c_new;
	logic              take_best;
	logic [RIDX_W-1:0] nb_room;
	logic [CW-1:0]     nb_count;
	always_comb begin
		c_cur     = valid_q[pick_q] ? bk_rdata : '0;
		c_new     = (&c_cur) ? c_cur : c_cur + CW'(1);
		take_best = (c_new > best_count_q) ||
		            (c_new == best_count_q && pick_q < best_room_q);
		nb_room   = take_best ? pick_q : best_room_q;
		nb_count  = take_best ? c_new : best_count_q;
	end

	// result beat packing
	logic [31:0] room_w, broom_w;
	logic [63:0] beg_w, fin_w;
	always_comb begin
		room_w  = 32'(pick_q);
		broom_w = 32'(nb_room);
		beg_w   = 64'(begin_q);
		fin_w   = 64'(finish_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q        <= lfrs_pkg::CFG_RESET;
			valid_q      <= '0;
			rv_s1        <= 1'b0;
			m_tvalid_q   <= 1'b0;
			best_room_q  <= '0;
			best_count_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				cfg_q <= cfg_wr_data;
			end
			rv_s1 <= fa_rd_en;
			if (wb_en) begin
				valid_q[pick_q] <= 1'b1;
				best_room_q     <= nb_room;
				best_count_q    <= nb_count;
				m_tvalid_q      <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ri_s1 <= ra_q[RIDX_W-1:0];
		if (accept) begin
			start_q <= s_tdata[RW-1:0];
			end_q   <= s_tdata[2*RW-1:RW];
			dur_q   <= (s_tdata[2*RW-1:RW] > s_tdata[RW-1:0]) ?
			           s_tdata[2*RW-1:RW] - s_tdata[RW-1:0] : '0;
			ra_q    <= '0;
			found_q <= 1'b0;
		end
		if (fa_rd_en) begin
			ra_q <= ra_q + CNT_W'(1);
		end
		// first free room wins; otherwise keep the earliest, lower index on ties
		if (state_q == lfrs_pkg::ST_SCAN && rv_s1 && !found_q) begin
			if (fa_cur <= TIME_BITS'(start_q)) begin
				found_q <= 1'b1;
				pick_q  <= ri_s1;
			end else if (ri_s1 == '0 || fa_cur < min_q) begin
				min_q     <= fa_cur;
				min_idx_q <= ri_s1;
			end
		end
		if (state_q == lfrs_pkg::ST_PICK) begin
			if (found_q) begin
				begin_q  <= TIME_BITS'(start_q);
				finish_q <= TIME_BITS'(end_q);
			end else begin
				pick_q   <= min_idx_q;
				begin_q  <= min_q;
				finish_q <= sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
			end
		end
		if (wb_en) begin
			m_tdata_q <= {{lfrs_pkg::M_PAD_W{1'b0}}, nb_count,
			              broom_w[lfrs_pkg::ROOM_OUT_W-1:0], !found_q,
			              fin_w[lfrs_pkg::OUT_TIME_W-1:0], beg_w[lfrs_pkg::OUT_TIME_W-1:0],
			              room_w[lfrs_pkg::ROOM_OUT_W-1:0]};
		end
	end

	assign bk_rd_addr = found_q ? pick_q : min_idx_q;
	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;

	// room busy-until times
	lfrs_ram #(
		.WIDTH (TIME_BITS),
		.DEPTH (MAX_ROOMS)
	) u_free_at (
		.clk     (clk),
		.wr_en   (wb_en),
		.wr_addr (pick_q),
		.wr_data (finish_q),
		.rd_en   (fa_rd_en),
		.rd_addr (ra_q[RIDX_W-1:0]),
		.rd_data (fa_rdata)
	);

	// per-room booking counts
	lfrs_ram #(
		.WIDTH (CW),
		.DEPTH (MAX_ROOMS)
	) u_bookings (
		.clk     (clk),
		.wr_en   (wb_en),
		.wr_addr (pick_q),
		.wr_data (c_new),
		.rd_en   (bk_rd_en),
		.rd_addr (bk_rd_addr),
		.rd_data (bk_rdata)
	);

	// write-back only ever targets an active room
	a_pick_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wb_en |-> (CNT_W'(pick_q) < n_rooms))
		else $error("room picked outside the active range");

	// busiest count never falls
	a_best_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		wb_en |=> (best_count_q >= $past(best_count_q)))
		else $error("busiest count decreased");

	// a delayed booking never begins before its requested start nor ends before it begins
	a_delay_order: assert property (@(posedge clk) disable iff (!arst_n)
		(wb_en && !found_q) |-> (begin_q > TIME_BITS'(start_q) && finish_q >= begin_q))
		else $error("delayed booking times out of order");

	// no new booking is taken while the scan or write-back is running
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("booking accepted during processing");

endmodule

`default_nettype wire

// ===== sim/lfrs_booking_checker.sv =====
// booking checker: watches the channels, predicts each result beat and compares it
`timescale 1ns / 100ps

module lfrs_booking_checker
	import lfrs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_W-1:0]      cfg_wr_data,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [M_TDATA_W-1:0]  m_tdata,
	output int                    mismatches,
	output int                    outstanding,
	output int                    results_seen,
	output int                    delayed_seen
);

	localparam int ROOMS    = DEF_MAX_ROOMS;
	localparam int TIME_W   = DEF_TIME_BITS;

	// result beat layout, lowest bit up
	localparam int ROOM_LO      = 0;
	localparam int BEGIN_LO     = ROOM_LO + ROOM_OUT_W;
	localparam int FINISH_LO    = BEGIN_LO + OUT_TIME_W;
	localparam int DELAY_BIT    = FINISH_LO + OUT_TIME_W;
	localparam int TOP_ROOM_LO  = DELAY_BIT + 1;
	localparam int TOP_COUNT_LO = TOP_ROOM_LO + ROOM_OUT_W;

	typedef struct packed {
		logic [ROOM_OUT_W-1:0] room;
		logic [OUT_TIME_W-1:0] act_begin;
		logic [OUT_TIME_W-1:0] act_finish;
		logic                  delayed;
		logic [ROOM_OUT_W-1:0] top_room;
		logic [COUNT_W-1:0]    top_count;
	} room_result_t;

	logic [TIME_W-1:0]     room_busy_until [ROOMS];
	logic [COUNT_W-1:0]    room_use_count  [ROOMS];
	logic [ROOM_OUT_W-1:0] top_room;
	logic [COUNT_W-1:0]    top_count;
	logic [CFG_W-1:0]      rooms_setting;
	room_result_t          pending_results [$];

	// assign one booking to a room and update the room tables
	task automatic assign_room(input logic [REQ_TIME_W-1:0] start_t,
			input logic [REQ_TIME_W-1:0] end_t, output room_result_t res);
		int                 n;
		int                 i;
		int                 pick;
		logic               hit;
		logic [TIME_W-1:0]  span;
		logic [TIME_W:0]    sum;
		logic [TIME_W-1:0]  finish;
		logic [COUNT_W-1:0] cnt;
		begin
			n = (rooms_setting == 0) ? 1 :
				((rooms_setting > ROOMS) ? ROOMS : int'(rooms_setting));
			span = (end_t > start_t) ? TIME_W'(end_t - start_t) : '0;
			hit = 1'b0;
			pick = 0;
			for (i = 0; i < n; i++) begin
				if (!hit && room_busy_until[i] <= TIME_W'(start_t)) begin
					hit = 1'b1;
					pick = i;
				end
			end
			if (hit) begin
				res.act_begin = OUT_TIME_W'(start_t);
				finish = TIME_W'(end_t);
			end else begin
				// nobody free: earliest release wins, lower index on ties
				pick = 0;
				for (i = 1; i < n; i++)
					if (room_busy_until[i] < room_busy_until[pick])
						pick = i;
				res.act_begin = OUT_TIME_W'(room_busy_until[pick]);
				sum = {1'b0, room_busy_until[pick]} + {1'b0, span};
				finish = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
			end
			room_busy_until[pick] = finish;
			cnt = room_use_count[pick];
			if (cnt != '1)
				cnt = cnt + 1'b1;
			room_use_count[pick] = cnt;
			if (cnt > top_count || (cnt == top_count && pick < top_room)) begin
				top_count = cnt;
				top_room = ROOM_OUT_W'(pick);
			end
			res.room = ROOM_OUT_W'(pick);
			res.act_finish = OUT_TIME_W'(finish);
			res.delayed = !hit;
			res.top_room = top_room;
			res.top_count = top_count;
		end
	endtask

	task automatic compare_field(input string label, input logic [OUT_TIME_W-1:0] want,
			input logic [OUT_TIME_W-1:0] got);
		if (want !== got) begin
			$display("%0t: result %0d %s expected 0x%0h got 0x%0h",
				$time, results_seen, label, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		room_result_t want;
		room_result_t got;
		if (!arst_n) begin
			for (int i = 0; i < ROOMS; i++) begin
				room_busy_until[i] = '0;
				room_use_count[i] = '0;
			end
			top_room = '0;
			top_count = '0;
			rooms_setting = CFG_RESET;
			pending_results.delete();
			mismatches = 0;
			outstanding = 0;
			results_seen = 0;
			delayed_seen = 0;
		end else begin
			if (cfg_wr_en)
				rooms_setting = cfg_wr_data;
			// the result leaving now always belongs to an older booking
			if (m_tvalid && m_tready) begin
				got.room       = m_tdata[ROOM_LO +: ROOM_OUT_W];
				got.act_begin  = m_tdata[BEGIN_LO +: OUT_TIME_W];
				got.act_finish = m_tdata[FINISH_LO +: OUT_TIME_W];
				got.delayed    = m_tdata[DELAY_BIT];
				got.top_room   = m_tdata[TOP_ROOM_LO +: ROOM_OUT_W];
				got.top_count  = m_tdata[TOP_COUNT_LO +: COUNT_W];
				if (pending_results.size() == 0) begin
					$display("%0t: result beat with no booking outstanding, got 0x%0h",
						$time, m_tdata);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					compare_field("room", want.room, got.room);
					compare_field("actual_begin", want.act_begin, got.act_begin);
					compare_field("actual_finish", want.act_finish, got.act_finish);
					compare_field("was_delayed", want.delayed, got.delayed);
					compare_field("busiest_room", want.top_room, got.top_room);
					compare_field("busiest_count", want.top_count, got.top_count);
					if (want.delayed)
						delayed_seen++;
				end
				results_seen++;
			end
			if (s_tvalid && s_tready) begin
				assign_room(s_tdata[0 +: REQ_TIME_W], s_tdata[REQ_TIME_W +: REQ_TIME_W], want);
				pending_results.push_back(want);
			end
			outstanding = pending_results.size();
		end
	end

endmodule

// ===== sim/tb_lowest_free_room_scheduler.sv =====
// testbench top: booking stimulus, idle mixes, watchdog and verdict
`timescale 1ns / 100ps

module tb_lowest_free_room_scheduler;

	import lfrs_pkg::*;

	localparam int ITEMS          = 1650;
	localparam int DIRECTED_ITEMS = 25;
	localparam int PHASES         = 8;
	// no beat may stall longer than this; far beyond any slow but correct run
	localparam int WATCHDOG_LIMIT = 2000;
	// wait after the final drain, so that a stray beat from the block can show
	localparam int SETTLE_CYCLES  = 25;

	localparam logic [REQ_TIME_W-1:0] T_MAX = '1;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_W-1:0]      cfg_wr_data;
	logic                  s_tvalid;
	logic                  s_tready;
	// start_time, end_time
	logic [S_TDATA_W-1:0]  s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	// room, actual_begin, actual_finish, was_delayed, busiest_room, busiest_count, zero pad
	logic [M_TDATA_W-1:0]  m_tdata;

	int                    mismatches;
	int                    outstanding;
	int                    results_seen;
	int                    delayed_seen;

	// idle chances in percent, changed from phase to phase
	int                    sender_idle_pct;
	int                    receiver_stall_pct;
	int                    settings_used;
	int                    stalled_cycles;
	// start of the current well-ordered booking timeline
	logic [REQ_TIME_W-1:0] timeline;

	lowest_free_room_scheduler u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

	lfrs_booking_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.results_seen (results_seen),
		.delayed_seen (delayed_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side: random back-pressure at the current stall rate
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	// watchdog: any cycle in which no beat moves counts toward the limit
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stalled_cycles <= 0;
		end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
			stalled_cycles <= 0;
		end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles, %0d results outstanding",
				$time, WATCHDOG_LIMIT, outstanding);
			$display("*** FAILED ***");
			$finish;
		end else begin
			stalled_cycles <= stalled_cycles + 1;
		end
	end

	// present one booking beat, with random sender gaps ahead of it, and hold it
	// until the block takes it; valid stays high for a following beat
	task automatic send_booking(input logic [REQ_TIME_W-1:0] start_t,
			input logic [REQ_TIME_W-1:0] end_t);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {end_t, start_t};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// sender goes quiet until every predicted result has come back
	task automatic wait_all_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	// room count register, only written while the block is idle
	task automatic write_rooms(input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		settings_used++;
	endtask

	// mostly well-ordered bookings along a timeline, the rest out of order,
	// end-before-start, or fully random noise
	task automatic random_booking();
		int unsigned           kind;
		logic [REQ_TIME_W-1:0] step;
		logic [REQ_TIME_W-1:0] span;
		logic [REQ_TIME_W-1:0] st;
		logic [REQ_TIME_W-1:0] en;
		begin
			kind = $urandom_range(99);
			if (kind < 80) begin
				case ($urandom_range(7))
					0, 1:    step = '0;
					2, 3, 4: step = $urandom_range(8);
					5, 6:    step = $urandom_range(200);
					default: step = ($urandom_range(31) == 0) ? $urandom : $urandom_range(5000);
				endcase
				// running off the top restarts the timeline near zero
				if (timeline > T_MAX - step)
					timeline = $urandom_range(100);
				else
					timeline = timeline + step;
				st = timeline;
				case ($urandom_range(15))
					0:          span = 1;
					1, 2, 3, 4: span = $urandom_range(1, 40);
					5, 6, 7, 8: span = $urandom_range(1, 300);
					15:         span = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 100000);
					default:    span = $urandom_range(1, 2000);
				endcase
				en = (st > T_MAX - span) ? T_MAX : st + span;
			end else if (kind < 88) begin
				// start order broken: a little behind the timeline
				step = $urandom_range(1, 5000);
				st = (timeline > step) ? timeline - step : '0;
				span = $urandom_range(0, 2000);
				en = (st > T_MAX - span) ? T_MAX : st + span;
			end else if (kind < 95) begin
				// end not after start
				step = $urandom_range(0, 50);
				st = timeline;
				en = (timeline > step) ? timeline - step : '0;
			end else begin
				st = $urandom;
				en = $urandom;
			end
			send_booking(st, en);
		end
	endtask

	initial begin
		int phase;
		int per_phase;
		logic [CFG_W-1:0] plan;
		arst_n             = 1'b0;
		cfg_wr_en          = 1'b0;
		cfg_wr_data        = '0;
		s_tvalid           = 1'b0;
		s_tdata            = '0;
		m_tready           = 1'b0;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		settings_used      = 0;
		timeline           = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// directed: reset room count of 16, zero length and full range bookings,
		// end before start, the top of the start range
		send_booking('0, '0);
		send_booking('0, T_MAX);
		send_booking('0, 32'd10);
		send_booking(32'd10, 32'd3);
		send_booking(T_MAX, T_MAX);

		// a room count of zero acts as one: every booking is pushed back, and the
		// finish runs past 32 bits
		wait_all_results();
		write_rooms(5'd0);
		send_booking(32'd5, 32'd5);
		send_booking(32'd6, T_MAX);
		send_booking(32'h8000_0000, 32'h8000_0001);
		send_booking(T_MAX, '0);

		// an oversized count clamps to all rooms: fill the idle ones, then one more
		// that has to wait and lands on a tie
		wait_all_results();
		write_rooms(5'd31);
		repeat (15)
			send_booking(32'd100, 32'd1000);
		send_booking(32'd100, 32'd200);

		// random phases: each one a new room count and an idle mix
		per_phase = (ITEMS - DIRECTED_ITEMS) / PHASES;
		for (phase = 0; phase < PHASES; phase++) begin
			wait_all_results();
			case (phase)
				0:       plan = 5'd16;
				1:       plan = 5'd1;
				2:       plan = 5'd3;
				3:       plan = 5'd31;
				4:       plan = 5'd0;
				5:       plan = 5'd8;
				6:       plan = 5'd17;
				default: plan = 5'd5;
			endcase
			write_rooms(plan);
			case (phase % 4)
				0: begin
					sender_idle_pct    = 0;
					receiver_stall_pct = 0;
				end
				1: begin
					sender_idle_pct    = 85;
					receiver_stall_pct = 0;
				end
				2: begin
					sender_idle_pct    = 0;
					receiver_stall_pct = 85;
				end
				default: begin
					sender_idle_pct    = 36;
					receiver_stall_pct = 36;
				end
			endcase
			repeat (per_phase)
				random_booking();
		end

		// drain, then give the block time to show anything stray
		wait_all_results();
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("run covered %0d bookings, %0d of them delayed, over %0d room count settings",
			results_seen, delayed_seen, settings_used);
		$display("idle mixes: none, sender gaps, receiver stalls, and both together");
		if (mismatches == 0 && outstanding == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/lfrs_pkg.sv
rtl/lfrs_ram.sv
rtl/lowest_free_room_scheduler.sv
sim/lfrs_booking_checker.sv
sim/tb_lowest_free_room_scheduler.sv
